>>> src/bprr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bprr_pkg
// Shared types and constants for the round-robin buffer pool slot manager.
// ----------------------------------------------------------------------------
package bprr_pkg;

  localparam int SLOT_W = 4;
  localparam int BADDR_W = 32;
  localparam int OP_W = 2;

  typedef enum logic [OP_W-1:0] {
    OP_ACCESS = 2'd0,
    OP_LOCK   = 2'd1,
    OP_UNLOCK = 2'd2
  } op_t;

  // controller to datapath commands
  typedef struct packed {
    logic load_in;
    logic look;
    logic commit;
  } dp_cmd_t;

endpackage

>>> src/bprr_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bprr_ctrl
// Sequencer: takes an item, runs the lookup cycle, then commits the result
// into the output register when that register is free.
// ----------------------------------------------------------------------------
module bprr_ctrl
  import bprr_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  output dp_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_LOOK = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free    = !out_valid_r || out_ready;
  assign in_ready    = (state_r == S_IDLE) || ((state_r == S_DONE) && out_free);
  assign cmd.load_in = in_valid && in_ready;
  assign cmd.look    = (state_r == S_LOOK);
  assign cmd.commit  = (state_r == S_DONE) && out_free;
  assign out_valid   = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_LOOK;
      end
      S_LOOK: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) state_nxt = in_valid ? S_LOOK : S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.commit) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> src/bprr_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bprr_datapath
// Tag store, valid and lock bits, victim pointer, associative compare,
// victim search and the result register.
// ----------------------------------------------------------------------------
module bprr_datapath
  import bprr_pkg::*;
#(
  parameter int SLOTS     = 16,
  parameter int ADDR_BITS = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  dp_cmd_t            cmd,
  input  logic [OP_W-1:0]    in_op,
  input  logic [BADDR_W-1:0] in_block_addr,
  input  logic [SLOT_W-1:0]  in_slot_sel,
  output logic [SLOT_W-1:0]  out_slot,
  output logic               out_hit,
  output logic               out_evict_valid,
  output logic [BADDR_W-1:0] out_evict_addr,
  output logic               out_load_req,
  output logic               out_status
);

  localparam int IDX_W = $clog2(SLOTS);

  // item registers
  op_t                  op_r;
  logic [ADDR_BITS-1:0] addr_r;
  logic [SLOT_W-1:0]    sel_r;

  // pool state
  logic [ADDR_BITS-1:0] tag_r [SLOTS];
  logic [SLOTS-1:0]     valid_r, valid_nxt;
  logic [SLOTS-1:0]     lock_r, lock_nxt;
  logic [IDX_W-1:0]     ptr_r, ptr_nxt;

  // lookup results
  logic [SLOTS-1:0]     match_r, match_nxt;
  logic [IDX_W-1:0]     vict_r, vict_nxt;
  logic                 vict_ok_r, vict_ok_nxt;

  // result register
  logic [SLOT_W-1:0]    slot_r, slot_nxt;
  logic                 hit_r, hit_nxt;
  logic                 ev_r, ev_nxt;
  logic [BADDR_W-1:0]   eaddr_r, eaddr_nxt;
  logic                 load_r, load_nxt;
  logic                 status_r, status_nxt;

  logic [IDX_W-1:0]     vict_lo, vict_hi, hit_idx, sel_idx;
  logic                 found_lo, found_hi, hit_any, sel_ok, tag_we;

  // compare against every tag, and find the first unlocked slot from the pointer
  always_comb begin
    vict_lo  = '0;
    vict_hi  = '0;
    found_lo = 1'b0;
    found_hi = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      match_nxt[i] = valid_r[i] && (tag_r[i] == addr_r);
    end
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!lock_r[i]) begin
        vict_lo  = IDX_W'(i);
        found_lo = 1'b1;
        if (IDX_W'(i) >= ptr_r) begin
          vict_hi  = IDX_W'(i);
          found_hi = 1'b1;
        end
      end
    end
    vict_nxt    = found_hi ? vict_hi : vict_lo;
    vict_ok_nxt = found_lo;
  end

  always_comb begin
    hit_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (match_r[i]) hit_idx = IDX_W'(i);
    end
  end

  assign hit_any = |match_r;
  assign sel_idx = IDX_W'(sel_r);
  assign sel_ok  = (32'(sel_r) < SLOTS);

  always_comb begin
    slot_nxt   = '0;
    hit_nxt    = 1'b0;
    ev_nxt     = 1'b0;
    eaddr_nxt  = '0;
    load_nxt   = 1'b0;
    status_nxt = 1'b0;
    valid_nxt  = valid_r;
    lock_nxt   = lock_r;
    ptr_nxt    = ptr_r;
    tag_we     = 1'b0;
    case (op_r)
      OP_ACCESS: begin
        if (hit_any) begin
          slot_nxt = SLOT_W'(hit_idx);
          hit_nxt  = 1'b1;
        end else if (vict_ok_r) begin
          slot_nxt          = SLOT_W'(vict_r);
          ev_nxt            = valid_r[vict_r];
          eaddr_nxt         = valid_r[vict_r] ? BADDR_W'(tag_r[vict_r]) : '0;
          load_nxt          = 1'b1;
          valid_nxt[vict_r] = 1'b1;
          tag_we            = 1'b1;
          ptr_nxt = (32'(vict_r) == SLOTS - 1) ? '0 : vict_r + IDX_W'(1);
        end else begin
          status_nxt = 1'b1;
        end
      end
      OP_LOCK, OP_UNLOCK: begin
        slot_nxt = sel_r;
        if (sel_ok) lock_nxt[sel_idx] = (op_r == OP_LOCK);
      end
      default: begin
        slot_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      lock_r  <= '0;
      ptr_r   <= '0;
    end else if (cmd.commit) begin
      valid_r <= valid_nxt;
      lock_r  <= lock_nxt;
      ptr_r   <= ptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && tag_we) tag_r[vict_r] <= addr_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_r   <= op_t'(in_op);
      addr_r <= ADDR_BITS'(in_block_addr);
      sel_r  <= in_slot_sel;
    end
    if (cmd.look) begin
      match_r   <= match_nxt;
      vict_r    <= vict_nxt;
      vict_ok_r <= vict_ok_nxt;
    end
    if (cmd.commit) begin
      slot_r   <= slot_nxt;
      hit_r    <= hit_nxt;
      ev_r     <= ev_nxt;
      eaddr_r  <= eaddr_nxt;
      load_r   <= load_nxt;
      status_r <= status_nxt;
    end
  end

  assign out_slot        = slot_r;
  assign out_hit         = hit_r;
  assign out_evict_valid = ev_r;
  assign out_evict_addr  = eaddr_r;
  assign out_load_req    = load_r;
  assign out_status      = status_r;

endmodule

>>> src/buffer_pool_round_robin_replace_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// buffer_pool_round_robin_replace_top
// Fully associative buffer pool with round-robin replacement and slot pinning.
// ----------------------------------------------------------------------------
// Each item passes a lookup state, which compares the address with all SLOTS
// tags in parallel and searches for the first unlocked slot at or after the
// victim pointer, and then a commit state, which commits the result and updates
// the pool. A new item is taken in the commit cycle while the output register
// drains; the result register lets an item be taken while the previous result
// still waits. An access that finds every slot locked reports status 1 and
// changes nothing. Valid and lock bits clear at reset, tags do not.
module buffer_pool_round_robin_replace_top
  import bprr_pkg::*;
#(
  parameter int SLOTS     = 16,
  parameter int ADDR_BITS = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [OP_W-1:0]    in_op,
  input  logic [BADDR_W-1:0] in_block_addr,
  input  logic [SLOT_W-1:0]  in_slot_sel,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [SLOT_W-1:0]  out_slot,
  output logic               out_hit,
  output logic               out_evict_valid,
  output logic [BADDR_W-1:0] out_evict_addr,
  output logic               out_load_req,
  output logic               out_status
);

  dp_cmd_t cmd;

  bprr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  bprr_datapath #(
    .SLOTS     (SLOTS),
    .ADDR_BITS (ADDR_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_op           (in_op),
    .in_block_addr   (in_block_addr),
    .in_slot_sel     (in_slot_sel),
    .out_slot        (out_slot),
    .out_hit         (out_hit),
    .out_evict_valid (out_evict_valid),
    .out_evict_addr  (out_evict_addr),
    .out_load_req    (out_load_req),
    .out_status      (out_status)
  );

`ifndef SYNTHESIS
  // a result never overwrites one still waiting
  a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (!out_valid || out_ready))
    else $error("commit while result pending");

  // an accepted item always gets its lookup cycle before commit
  a_look_first: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (cmd.look && !cmd.commit))
    else $error("commit without lookup");

  a_hit_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_hit) |-> (!out_load_req && !out_evict_valid && !out_status))
    else $error("hit with replacement");

  a_evict_load: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_evict_valid) |-> (out_load_req && !out_status))
    else $error("eviction without load");
`endif

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the round-robin buffer pool slot manager against a cycle-free
// prediction of its slot tags, valid marks, pins and victim pointer. Directed
// items cover hits, fills, pinned hits, victim skipping, an all-pinned miss and
// the unused op code; random accesses, half over a small address set, mix with
// lock, unlock and unused ops under varying idle on both channels.
// ----------------------------------------------------------------------------
module testbench;
  import bprr_pkg::*;

  localparam int POOL_SLOTS = 16;
  localparam int ADDR_SET = 24;
  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_EVERY = 150;
  localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;

  typedef struct packed {
    logic [SLOT_W-1:0]  slot;
    logic               hit;
    logic               evict_valid;
    logic [BADDR_W-1:0] evict_addr;
    logic               load_req;
    logic               status;
  } pool_result_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [OP_W-1:0]    in_op = '0;
  logic [BADDR_W-1:0] in_block_addr = '0;
  logic [SLOT_W-1:0]  in_slot_sel = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [SLOT_W-1:0]  out_slot;
  logic               out_hit;
  logic               out_evict_valid;
  logic [BADDR_W-1:0] out_evict_addr;
  logic               out_load_req;
  logic               out_status;

  // shadow copy of the pool
  logic [BADDR_W-1:0] shadow_tags [POOL_SLOTS];
  logic               shadow_resident [POOL_SLOTS];
  logic               shadow_pinned [POOL_SLOTS];
  logic [SLOT_W-1:0]  shadow_victim;

  pool_result_t pending_results [$];
  pool_result_t head_result;
  logic [BADDR_W-1:0] addr_set [ADDR_SET];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int mismatch_count = 0;
  int items_sent = 0;
  int hit_count = 0;
  int writeback_count = 0;
  int all_pinned_count = 0;
  int stall_cycles = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  buffer_pool_round_robin_replace_top u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_op          (in_op),
    .in_block_addr  (in_block_addr),
    .in_slot_sel    (in_slot_sel),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_slot       (out_slot),
    .out_hit        (out_hit),
    .out_evict_valid(out_evict_valid),
    .out_evict_addr (out_evict_addr),
    .out_load_req   (out_load_req),
    .out_status     (out_status)
  );

  function automatic pool_result_t predict_pool(logic [OP_W-1:0] op, logic [BADDR_W-1:0] addr,
                                                logic [SLOT_W-1:0] sel);
    pool_result_t res;
    logic found;
    int v;
    res = '0;
    found = 1'b0;
    case (op)
      OP_LOCK, OP_UNLOCK: begin
        if (sel < POOL_SLOTS) shadow_pinned[sel] = (op == OP_LOCK);
        res.slot = sel;
      end
      OP_ACCESS: begin
        for (int i = 0; i < POOL_SLOTS; i++) begin
          if (!found && shadow_resident[i] && shadow_tags[i] == addr) begin
            found = 1'b1;
            res.slot = SLOT_W'(i);
            res.hit = 1'b1;
          end
        end
        // miss: first unpinned slot from the victim pointer onwards
        for (int k = 0; k < POOL_SLOTS; k++) begin
          v = (int'(shadow_victim) + k) % POOL_SLOTS;
          if (!found && !shadow_pinned[v]) begin
            found = 1'b1;
            res.slot = SLOT_W'(v);
            res.evict_valid = shadow_resident[v];
            res.evict_addr = shadow_resident[v] ? shadow_tags[v] : '0;
            res.load_req = 1'b1;
            shadow_tags[v] = addr;
            shadow_resident[v] = 1'b1;
            shadow_victim = SLOT_W'((v + 1) % POOL_SLOTS);
          end
        end
        if (!found) res.status = 1'b1;
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic send_item(logic [OP_W-1:0] op, logic [BADDR_W-1:0] addr,
                           logic [SLOT_W-1:0] sel);
    pool_result_t res;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_block_addr <= addr;
    in_slot_sel <= sel;
    do @(posedge clk); while (!in_ready);
    res = predict_pool(op, addr, sel);
    pending_results.push_back(res);
    items_sent++;
    if (res.hit) hit_count++;
    if (res.evict_valid) writeback_count++;
    if (res.status) all_pinned_count++;
  endtask

  // hold the sender off until every outstanding item has come back
  task automatic drain_pool();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic check_field(string name, logic [BADDR_W-1:0] exp, logic [BADDR_W-1:0] got);
    if (exp !== got) begin
      $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, exp, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t ns: result with no item outstanding, slot %0h", $time, out_slot);
        mismatch_count++;
      end else begin
        head_result = pending_results.pop_front();
        check_field("slot", BADDR_W'(head_result.slot), BADDR_W'(out_slot));
        check_field("hit", BADDR_W'(head_result.hit), BADDR_W'(out_hit));
        check_field("evict_valid", BADDR_W'(head_result.evict_valid),
                    BADDR_W'(out_evict_valid));
        check_field("evict_addr", head_result.evict_addr, out_evict_addr);
        check_field("load_req", BADDR_W'(head_result.load_req), BADDR_W'(out_load_req));
        check_field("status", BADDR_W'(head_result.status), BADDR_W'(out_status));
      end
    end
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t ns: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("status: fail");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic test_hit_and_miss();
    send_item(OP_ACCESS, 32'h0000_0000, 4'hF);
    send_item(OP_ACCESS, 32'hFFFF_FFFF, 4'h0);
    send_item(OP_ACCESS, 32'h0000_0000, 4'hF);
  endtask

  task automatic test_pinning();
    send_item(OP_LOCK, 32'hFFFF_FFFF, 4'h0);
    send_item(OP_LOCK, 32'h0000_0000, 4'hF);
    // a pinned slot still hits
    send_item(OP_ACCESS, 32'h0000_0000, 4'h0);
  endtask

  task automatic test_all_pinned();
    for (int s = 1; s < POOL_SLOTS - 1; s++) send_item(OP_LOCK, $urandom(), SLOT_W'(s));
    send_item(OP_ACCESS, 32'h5A5A_A5A5, 4'h3);
    send_item(OP_UNLOCK, 32'h0000_0000, 4'h7);
    // victim search has to skip the pinned run up to slot seven
    send_item(OP_ACCESS, 32'hA5A5_5A5A, 4'hC);
  endtask

  task automatic test_reserved_op();
    send_item(OP_RESERVED, 32'hFFFF_FFFF, 4'hF);
  endtask

  task automatic test_random_traffic(int n_items, int s_idle, int r_idle);
    int r;
    logic [OP_W-1:0] op;
    logic [BADDR_W-1:0] addr;
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    // a few more addresses than slots, so both hits and write-backs are common
    for (int a = 0; a < ADDR_SET; a++) addr_set[a] = $urandom();
    for (int n = 0; n < n_items; n++) begin
      r = $urandom_range(99);
      if (r < 68) op = OP_ACCESS;
      else if (r < 80) op = OP_LOCK;
      else if (r < 96) op = OP_UNLOCK;
      else op = OP_RESERVED;
      addr = $urandom_range(1) ? addr_set[$urandom_range(ADDR_SET - 1)] : $urandom();
      send_item(op, addr, SLOT_W'($urandom_range(POOL_SLOTS - 1)));
      if (n % DRAIN_EVERY == DRAIN_EVERY - 1) drain_pool();
    end
    drain_pool();
  endtask

  initial begin
    for (int s = 0; s < POOL_SLOTS; s++) begin
      shadow_tags[s] = '0;
      shadow_resident[s] = 1'b0;
      shadow_pinned[s] = 1'b0;
    end
    shadow_victim = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_idle_pct = 28;
    recv_idle_pct = 52;
    test_hit_and_miss();
    test_pinning();
    test_all_pinned();
    test_reserved_op();
    drain_pool();
    test_random_traffic(560, 28, 52);
    test_random_traffic(560, 52, 28);
    test_random_traffic(560, 0, 0);
    $display("run covered %0d items: %0d hits, %0d write-backs, %0d all-pinned misses",
             items_sent, hit_count, writeback_count, all_pinned_count);
    $display("mismatches seen: %0d", mismatch_count);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
